/* sv/squvd_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the URL query validator/decoder.
// No dependencies; used by the interfaces, the step logic and the top level.
package squvd_pkg;

  localparam int CODE_UNIT_W  = 16;
  localparam int CODE_POINT_W = 21;
  localparam int PART_KIND_W  = 2;

  localparam logic [1:0] PH_NAME  = 2'd0;
  localparam logic [1:0] PH_KEY   = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;

  localparam logic [1:0] ESC_IDLE = 2'd0;
  localparam logic [1:0] ESC_HIGH = 2'd1;
  localparam logic [1:0] ESC_LOW  = 2'd2;

  localparam logic [CODE_UNIT_W-1:0] CH_SLASH   = 16'h002F;
  localparam logic [CODE_UNIT_W-1:0] CH_PERCENT = 16'h0025;
  localparam logic [CODE_UNIT_W-1:0] CH_QMARK   = 16'h003F;
  localparam logic [CODE_UNIT_W-1:0] CH_EQUALS  = 16'h003D;
  localparam logic [CODE_UNIT_W-1:0] CH_AMP     = 16'h0026;

  localparam logic [CODE_POINT_W-1:0] MIN_TWO_BYTE   = 21'h00080;
  localparam logic [CODE_POINT_W-1:0] MIN_THREE_BYTE = 21'h00800;
  localparam logic [CODE_POINT_W-1:0] MIN_FOUR_BYTE  = 21'h10000;
  localparam logic [CODE_POINT_W-1:0] MAX_CODE_POINT = 21'h10FFFF;
  localparam logic [CODE_POINT_W-1:0] SURR_LOW       = 21'h0D800;
  localparam logic [CODE_POINT_W-1:0] SURR_HIGH      = 21'h0DFFF;

  typedef struct packed {
    logic [1:0]              phase;
    logic                    failed;
    logic [1:0]              escape_stage;
    logic [3:0]              high_nibble;
    logic [1:0]              bytes_left;
    logic [CODE_POINT_W-1:0] code_accumulator;
    logic [1:0]              length_class;
    logic                    part_nonempty;
    logic                    at_string_start;
  } squvd_state_t;

  localparam squvd_state_t ST_RESET = '{
    phase: PH_NAME, failed: 1'b0, escape_stage: ESC_IDLE, high_nibble: 4'd0,
    bytes_left: 2'd0, code_accumulator: '0, length_class: 2'd0,
    part_nonempty: 1'b0, at_string_start: 1'b1
  };

  typedef struct packed {
    logic                    char_valid;
    logic [CODE_POINT_W-1:0] code_point;
    logic [PART_KIND_W-1:0]  part_kind;
    logic                    starts_part;
    logic                    done_res;
    logic                    accepted;
  } squvd_result_t;

  function automatic logic is_hex(input logic [CODE_UNIT_W-1:0] u);
    return (u >= 16'h0030 && u <= 16'h0039) ||
           (u >= 16'h0041 && u <= 16'h0046) ||
           (u >= 16'h0061 && u <= 16'h0066);
  endfunction

  function automatic logic [3:0] hex_val(input logic [CODE_UNIT_W-1:0] u);
    logic [3:0] v;
    if (u <= 16'h0039) begin
      v = u[3:0];
    end else begin
      v = u[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

/* sv/squvd_in_if.sv */
`timescale 1ns / 1ps
// Input channel: one UTF-16 code unit per transaction with an end-of-string mark.
// Depends on squvd_pkg for the field widths.
interface squvd_in_if;
  logic                               valid;
  logic                               ready;
  logic [squvd_pkg::CODE_UNIT_W-1:0]  code_unit;
  logic                               last_unit;

  modport source (output valid, output code_unit, output last_unit, input ready);
  modport sink (input valid, input code_unit, input last_unit, output ready);
endinterface

/* sv/squvd_out_if.sv */
`timescale 1ns / 1ps
// Output channel: one decoded result per transaction.
// Depends on squvd_pkg for the field widths.
interface squvd_out_if;
  logic                               valid;
  logic                               ready;
  logic                               char_valid;
  logic [squvd_pkg::CODE_POINT_W-1:0] code_point;
  logic [squvd_pkg::PART_KIND_W-1:0]  part_kind;
  logic                               starts_part;
  logic                               done_res;
  logic                               accepted;

  modport source (output valid, output char_valid, output code_point, output part_kind,
                  output starts_part, output done_res, output accepted, input ready);
  modport sink (input valid, input char_valid, input code_point, input part_kind,
                input starts_part, input done_res, input accepted, output ready);
endinterface

/* sv/script_url_query_validator_decoder_unit.sv */
`timescale 1ns / 1ps
// Top level of the URL query validator/decoder: input register, step logic, result register.
// Depends on squvd_pkg, squvd_in_if, squvd_out_if and squvd_step.
// An accepted unit waits in the input register and moves through squvd_step into the result
// register once that register is free (empty, or its result taken with result.ready).
// Throughput: one unit per cycle while result.ready is high; squvd_step is combinational.
// Reset: synchronous rst empties both registers and returns the parse state to the name part.
// After the last unit of a string the parse state returns to its reset value.
module script_url_query_validator_decoder_unit (
  input  logic         clk,
  input  logic         rst,
  squvd_in_if.sink     item,
  squvd_out_if.source  result
);
  import squvd_pkg::*;

  logic                    item_q_valid;
  logic [CODE_UNIT_W-1:0]  item_q_unit;
  logic                    item_q_last;
  logic                    res_valid;
  squvd_result_t           res;
  squvd_result_t           res_next;
  squvd_state_t            st;
  squvd_state_t            st_next;
  logic                    res_free;
  logic                    advance;

  assign res_free   = !res_valid || result.ready;
  assign advance    = item_q_valid && res_free;
  assign item.ready = !item_q_valid || advance;

  squvd_step u_step (
    .st        (st),
    .code_unit (item_q_unit),
    .last_unit (item_q_last),
    .st_next   (st_next),
    .res_next  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
      res_valid    <= 1'b0;
      st           <= ST_RESET;
    end else begin
      if (item.ready) item_q_valid <= item.valid;
      if (res_free)   res_valid    <= item_q_valid;
      if (advance)    st           <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      item_q_unit <= item.code_unit;
      item_q_last <= item.last_unit;
    end
    if (advance) res <= res_next;
  end

  assign result.valid       = res_valid;
  assign result.char_valid  = res.char_valid;
  assign result.code_point  = res.code_point;
  assign result.part_kind   = res.part_kind;
  assign result.starts_part = res.starts_part;
  assign result.done_res    = res.done_res;
  assign result.accepted    = res.accepted;

  a_empty_result_ready: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> item.ready)
    else $error("input stalled with an empty result register");

  a_last_clears_state: assert property (@(posedge clk) disable iff (rst)
    advance && item_q_last |=> st == ST_RESET)
    else $error("parse state not cleared after the last unit");

  a_no_char_fields_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.char_valid |->
      res.code_point == '0 && res.part_kind == '0 && !res.starts_part)
    else $error("character fields set without a character");

  a_verdict_with_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.accepted |-> res.done_res)
    else $error("verdict without end of string");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.char_valid |-> res.part_kind != 2'd3)
    else $error("invalid part kind");

endmodule

/* sv/squvd_step.sv */
`timescale 1ns / 1ps
// Per-unit step logic: syntax check, percent/UTF-8 decode, result and next state.
// Depends on squvd_pkg.
module squvd_step (
  input  squvd_pkg::squvd_state_t               st,
  input  logic [squvd_pkg::CODE_UNIT_W-1:0]     code_unit,
  input  logic                                  last_unit,
  output squvd_pkg::squvd_state_t               st_next,
  output squvd_pkg::squvd_result_t              res_next
);
  import squvd_pkg::*;

  always_comb begin
    squvd_state_t             n;
    squvd_result_t            r;
    logic                     fail;
    logic                     emit;
    logic [CODE_POINT_W-1:0]  cp;
    logic [7:0]               b;
    logic [CODE_POINT_W-1:0]  v;
    logic [CODE_POINT_W-1:0]  lowest;

    n      = st;
    r      = '0;
    fail   = st.failed;
    emit   = 1'b0;
    cp     = '0;
    b      = {st.high_nibble, hex_val(code_unit)};
    v      = {st.code_accumulator[CODE_POINT_W-7:0], b[5:0]};
    lowest = (st.length_class == 2'd1) ? MIN_TWO_BYTE :
             (st.length_class == 2'd2) ? MIN_THREE_BYTE : MIN_FOUR_BYTE;

    if (!fail) begin
      if (st.at_string_start && code_unit == CH_SLASH) fail = 1'b1;
      n.at_string_start = 1'b0;
    end

    if (!fail) begin
      if (st.escape_stage == ESC_HIGH) begin
        if (!is_hex(code_unit)) begin
          fail = 1'b1;
        end else begin
          n.high_nibble  = hex_val(code_unit);
          n.escape_stage = ESC_LOW;
        end
      end else if (st.escape_stage == ESC_LOW) begin
        n.escape_stage = ESC_IDLE;
        if (!is_hex(code_unit)) begin
          fail = 1'b1;
        end else if (st.bytes_left == 2'd0) begin
          if (b[7] == 1'b0) begin
            emit = 1'b1;
            cp   = {{(CODE_POINT_W-8){1'b0}}, b};
          end else if (b[7:5] == 3'b110) begin
            n.code_accumulator = {{(CODE_POINT_W-5){1'b0}}, b[4:0]};
            n.bytes_left       = 2'd1;
            n.length_class     = 2'd1;
          end else if (b[7:4] == 4'b1110) begin
            n.code_accumulator = {{(CODE_POINT_W-4){1'b0}}, b[3:0]};
            n.bytes_left       = 2'd2;
            n.length_class     = 2'd2;
          end else if (b[7:3] == 5'b11110) begin
            n.code_accumulator = {{(CODE_POINT_W-3){1'b0}}, b[2:0]};
            n.bytes_left       = 2'd3;
            n.length_class     = 2'd3;
          end else begin
            fail = 1'b1;
          end
        end else if (b[7:6] != 2'b10) begin
          fail = 1'b1;
        end else begin
          n.code_accumulator = v;
          n.bytes_left       = st.bytes_left - 2'd1;
          if (n.bytes_left == 2'd0) begin
            if (v < lowest || v > MAX_CODE_POINT || (v >= SURR_LOW && v <= SURR_HIGH)) begin
              fail = 1'b1;
            end else begin
              emit = 1'b1;
              cp   = v;
            end
          end
        end
      end else if (code_unit == CH_PERCENT) begin
        n.escape_stage = ESC_HIGH;
      end else if (st.bytes_left != 2'd0) begin
        fail = 1'b1;
      end else if (st.phase == PH_NAME && code_unit == CH_QMARK) begin
        if (!st.part_nonempty) fail = 1'b1;
        n.phase         = PH_KEY;
        n.part_nonempty = 1'b0;
      end else if (st.phase == PH_KEY && code_unit == CH_EQUALS) begin
        if (!st.part_nonempty) fail = 1'b1;
        n.phase         = PH_VALUE;
        n.part_nonempty = 1'b0;
      end else if (st.phase == PH_KEY && code_unit == CH_AMP) begin
        fail = 1'b1;
      end else if (st.phase == PH_VALUE && code_unit == CH_AMP) begin
        n.phase         = PH_KEY;
        n.part_nonempty = 1'b0;
      end else if (st.phase == PH_VALUE && code_unit == CH_EQUALS) begin
        fail = 1'b1;
      end else if (st.phase > PH_VALUE) begin
        fail = 1'b1;
      end else begin
        emit = 1'b1;
        cp   = {{(CODE_POINT_W-CODE_UNIT_W){1'b0}}, code_unit};
      end
      if (fail) emit = 1'b0;
    end
    n.failed = fail;

    if (emit) begin
      r.char_valid    = 1'b1;
      r.code_point    = cp;
      r.part_kind     = st.phase;
      r.starts_part   = !st.part_nonempty;
      n.part_nonempty = 1'b1;
    end

    if (last_unit) begin
      r.done_res = 1'b1;
      r.accepted = !n.failed && n.escape_stage == ESC_IDLE && n.bytes_left == 2'd0 &&
                   ((n.phase == PH_NAME && n.part_nonempty) || n.phase == PH_VALUE);
      n = ST_RESET;
    end

    st_next  = n;
    res_next = r;
  end

endmodule
